/* hdl/dfr_pkg.sv */
// Shared types, constants and the CRC byte step for the frame deframer.
package dfr_pkg;

    // Payload buffer depth default
    localparam int DEF_PAYLOAD_DEPTH = 64;

    // Descriptor queue between parser and emitter
    localparam int QUEUE_DEPTH = 2;

    // APB address width and register indexes (paddr[3:2])
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
    localparam logic [1:0] REG_HDR_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_LEN    = 2'd2;

    // Register reset values
    localparam logic [7:0] RST_HDR_FIRST  = 8'hAA;
    localparam logic [7:0] RST_HDR_SECOND = 8'h55;
    localparam logic [6:0] RST_MAX_LEN    = 7'd64;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_TYPE,
        PH_LEN,
        PH_SEQ,
        PH_DATA,
        PH_CRCLO,
        PH_CRCHI
    } parse_phase_t;

    // Emitter states
    typedef enum logic [1:0] {
        EM_IDLE,
        EM_FETCH,
        EM_SEND
    } emit_state_t;

    // Verified frame descriptor
    typedef struct packed {
        logic [7:0] frame_type;
        logic [7:0] frame_seq;
        logic [6:0] data_len;
    } desc_t;

    // One byte through the CRC, MSB first
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/dfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/dfr_parser.sv */
// Front end: header hunt, field capture, CRC, payload write and descriptor push.
module dfr_parser #(
    parameter int PAYLOAD_DEPTH = dfr_pkg::DEF_PAYLOAD_DEPTH,
    parameter int AW            = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic [7:0]          header_first,
    input  logic [7:0]          header_second,
    input  logic [6:0]          max_len,
    input  logic                emit_busy,
    input  logic                q_full,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [7:0]          wr_data,
    output logic                push,
    output dfr_pkg::desc_t      push_desc
);
    import dfr_pkg::*;

    localparam logic [7:0] DEPTH_B = 8'(PAYLOAD_DEPTH);

    parse_phase_t phase_reg, phase_next;
    logic [7:0]   type_reg;
    logic [6:0]   len_reg;
    logic [7:0]   seq_reg;
    logic [6:0]   fill_reg;
    logic [7:0]   crclo_reg;
    logic [15:0]  crc_reg;

    logic         accept;
    logic [7:0]   limit;
    logic         too_long;
    logic [6:0]   fill_inc;
    logic [15:0]  crc_in;
    logic [15:0]  crc_new;
    logic         crc_ok;

    assign accept   = in_valid & in_ready;
    assign limit    = ({1'b0, max_len} > DEPTH_B) ? DEPTH_B : {1'b0, max_len};
    assign too_long = in_byte > limit;
    assign fill_inc = fill_reg + 7'd1;
    assign crc_in   = (phase_reg == PH_TYPE) ? CRC_INIT : crc_reg;
    assign crc_new  = crc_step(crc_in, in_byte);
    assign crc_ok   = {in_byte, crclo_reg} == crc_reg;

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_HDR1: begin
                    if (in_byte == header_first) phase_next = PH_HDR2;
                end
                PH_HDR2: begin
                    if (in_byte == header_second)     phase_next = PH_TYPE;
                    else if (in_byte == header_first) phase_next = PH_HDR2;
                    else                              phase_next = PH_HDR1;
                end
                PH_TYPE:  phase_next = PH_LEN;
                PH_LEN:   phase_next = too_long ? PH_HDR1 : PH_SEQ;
                PH_SEQ:   phase_next = (len_reg == 7'd0) ? PH_CRCLO : PH_DATA;
                PH_DATA: begin
                    if (fill_inc >= len_reg) phase_next = PH_CRCLO;
                end
                PH_CRCLO: phase_next = PH_CRCHI;
                PH_CRCHI: phase_next = PH_HDR1;
                default:  phase_next = PH_HDR1;
            endcase
        end
    end

    // Handshake, buffer write and descriptor push
    always_comb begin
        unique case (phase_reg)
            PH_DATA:  in_ready = !emit_busy;
            PH_CRCHI: in_ready = !q_full;
            default:  in_ready = 1'b1;
        endcase
        wr_en   = accept && (phase_reg == PH_DATA);
        wr_addr = fill_reg[AW-1:0];
        wr_data = in_byte;
        push    = accept && (phase_reg == PH_CRCHI) && crc_ok;
        push_desc.frame_type = type_reg;
        push_desc.frame_seq  = seq_reg;
        push_desc.data_len   = len_reg;
    end

    // Phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR1;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Frame fields and running CRC
    always_ff @(posedge aclk) begin
        if (accept) begin
            case (phase_reg)
                PH_TYPE: begin
                    type_reg <= in_byte;
                    crc_reg  <= crc_new;
                end
                PH_LEN: begin
                    crc_reg <= crc_new;
                    len_reg <= in_byte[6:0];
                end
                PH_SEQ: begin
                    seq_reg  <= in_byte;
                    crc_reg  <= crc_new;
                    fill_reg <= 7'd0;
                end
                PH_DATA: begin
                    crc_reg  <= crc_new;
                    fill_reg <= fill_inc;
                end
                PH_CRCLO: crclo_reg <= in_byte;
                default: ;
            endcase
        end
    end

endmodule

/* hdl/dfr_queue.sv */
// Short descriptor queue between parser and emitter.
module dfr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dfr_pkg::desc_t push_desc,
    input  logic           pop,
    output dfr_pkg::desc_t pop_desc,
    output logic           empty,
    output logic           full
);
    import dfr_pkg::*;

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QPW-1:0] PTR_LAST = QPW'(QUEUE_DEPTH - 1);
    localparam logic [QPW-1:0] PTR_ONE  = QPW'(1);
    localparam logic [QCW-1:0] CNT_FULL = QCW'(QUEUE_DEPTH);
    localparam logic [QCW-1:0] CNT_ONE  = QCW'(1);

    desc_t          entry_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg;

    assign empty    = count_reg == '0;
    assign full     = count_reg == CNT_FULL;
    assign pop_desc = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_ONE;
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_ONE;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

/* hdl/dfr_emitter.sv */
// Back end: reads the payload buffer and sends one item per payload byte, or a single item for an empty frame.
module dfr_emitter #(
    parameter int PAYLOAD_DEPTH = dfr_pkg::DEF_PAYLOAD_DEPTH,
    parameter int AW            = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  dfr_pkg::desc_t q_desc,
    output logic           pop,
    output logic           busy,
    output logic           rd_en,
    output logic [AW-1:0]  rd_addr,
    input  logic [7:0]     rd_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     frame_type,
    output logic [7:0]     frame_seq,
    output logic [6:0]     data_len,
    output logic [5:0]     byte_index,
    output logic [7:0]     payload_byte,
    output logic           has_byte,
    output logic           last
);
    import dfr_pkg::*;

    emit_state_t state_reg, state_next;
    desc_t       desc_reg;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_inc;
    logic        is_last;
    logic        sent;

    assign cnt_inc = cnt_reg + 7'd1;
    assign is_last = (desc_reg.data_len == 7'd0) || (cnt_inc == desc_reg.data_len);
    assign sent    = (state_reg == EM_SEND) && out_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE: begin
                if (!q_empty) begin
                    state_next = (q_desc.data_len == 7'd0) ? EM_SEND : EM_FETCH;
                end
            end
            EM_FETCH: state_next = EM_SEND;
            EM_SEND: begin
                if (out_ready) state_next = is_last ? EM_IDLE : EM_FETCH;
            end
            default: state_next = EM_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        pop          = (state_reg == EM_IDLE) && !q_empty;
        busy         = state_reg != EM_IDLE;
        rd_en        = state_reg == EM_FETCH;
        rd_addr      = cnt_reg[AW-1:0];
        out_valid    = state_reg == EM_SEND;
        frame_type   = desc_reg.frame_type;
        frame_seq    = desc_reg.frame_seq;
        data_len     = desc_reg.data_len;
        byte_index   = cnt_reg[5:0];
        has_byte     = desc_reg.data_len != 7'd0;
        payload_byte = has_byte ? rd_data : 8'h00;
        last         = is_last;
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Descriptor and byte counter
    always_ff @(posedge aclk) begin
        if (pop) begin
            desc_reg <= q_desc;
            cnt_reg  <= 7'd0;
        end else if (sent) begin
            cnt_reg <= cnt_inc;
        end
    end

endmodule

/* hdl/crc_checked_frame_deframer.sv */
// Top level of the CRC-checked serial frame deframer.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata[7:0] = rx_byte
//  m_       out  m_tvalid/m_tready  m_tdata (frame fields), m_tuser = has_byte, m_tlast = last
//  apb      in   psel/penable       header_first @0x0, header_second @0x4, max length @0x8
//
// Header, type, length, sequence and CRC low bytes are never stalled. Payload bytes
// stall while an earlier frame is still queued or being sent out of the single
// payload buffer; the CRC high byte stalls while the descriptor queue is full.
// Each result is read from the buffer and then presented, once the frame's descriptor
// has been taken; an empty frame skips the buffer read.
// Reset is synchronous, active low; the payload buffer needs no clearing.
module crc_checked_frame_deframer #(
    parameter int PAYLOAD_DEPTH = dfr_pkg::DEF_PAYLOAD_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input items: tdata = rx_byte[7:0]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,
    // result items: tdata = frame_type[7:0], frame_seq[15:8], data_len[22:16],
    // byte_index[28:23], payload_byte[36:29], zero[39:37]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,
    // tuser = has_byte[0]
    output logic [0:0]                   m_tuser,
    output logic                         m_tlast,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dfr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import dfr_pkg::*;

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    logic [7:0] header_first_reg;
    logic [7:0] header_second_reg;
    logic [6:0] max_len_reg;
    logic       cfg_wr;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;
    logic          push, pop, q_empty, q_full, em_busy, emit_busy;
    desc_t         push_desc, pop_desc;

    logic [7:0] frame_type, frame_seq, payload_byte;
    logic [6:0] data_len;
    logic [5:0] byte_index;
    logic       has_byte;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= RST_HDR_FIRST;
            header_second_reg <= RST_HDR_SECOND;
            max_len_reg       <= RST_MAX_LEN;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_HDR_FIRST:  header_first_reg  <= pwdata[7:0];
                REG_HDR_SECOND: header_second_reg <= pwdata[7:0];
                REG_MAX_LEN:    max_len_reg       <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HDR_FIRST:  prdata = {24'h0, header_first_reg};
            REG_HDR_SECOND: prdata = {24'h0, header_second_reg};
            REG_MAX_LEN:    prdata = {25'h0, max_len_reg};
            default:        prdata = 32'h0;
        endcase
    end

    // Buffer is owned by the emitter until every queued frame is sent
    assign emit_busy = em_busy | ~q_empty;

    dfr_parser #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .AW            (AW)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .header_first  (header_first_reg),
        .header_second (header_second_reg),
        .max_len       (max_len_reg),
        .emit_busy     (emit_busy),
        .q_full        (q_full),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .push          (push),
        .push_desc     (push_desc)
    );

    dfr_ram #(
        .WIDTH   (8),
        .DEPTH   (PAYLOAD_DEPTH),
        .AW      (AW)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .empty     (q_empty),
        .full      (q_full)
    );

    dfr_emitter #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .AW            (AW)
    ) u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_desc        (pop_desc),
        .pop           (pop),
        .busy          (em_busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .frame_type    (frame_type),
        .frame_seq     (frame_seq),
        .data_len      (data_len),
        .byte_index    (byte_index),
        .payload_byte  (payload_byte),
        .has_byte      (has_byte),
        .last          (m_tlast)
    );

    assign m_tdata = {3'b000, payload_byte, byte_index, data_len, frame_seq, frame_type};
    assign m_tuser = has_byte;

    // Checks
    a_no_buf_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && emit_busy))
        else $error("payload buffer written while a frame is being sent");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_full))
        else $error("descriptor pushed into a full queue");

    a_empty_frame_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata[36:16] == 21'h0))
        else $error("empty frame item not a lone last item");

    a_pop_starts_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> em_busy)
        else $error("emitter idle after taking a descriptor");

endmodule
